// ===== sv/thg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thg_pkg
// Shared types and constants for the tap and hold gesture detector.
// ----------------------------------------------------------------------------
package thg_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int ADDR_BITS = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LATCH_GAP = 2'd0;
    localparam logic [1:0] REG_TAP_MIN   = 2'd1;
    localparam logic [1:0] REG_TAP_MAX   = 2'd2;
    localparam logic [1:0] REG_HOLD      = 2'd3;

    localparam logic [CFG_BITS-1:0] LATCH_GAP_RST = 16'd300;
    localparam logic [CFG_BITS-1:0] TAP_MIN_RST   = 16'd30;
    localparam logic [CFG_BITS-1:0] TAP_MAX_RST   = 16'd1000;
    localparam logic [CFG_BITS-1:0] HOLD_RST      = 16'd1000;

    typedef struct packed {
        logic [CFG_BITS-1:0] latch_gap_ms;
        logic [CFG_BITS-1:0] tap_min_ms;
        logic [CFG_BITS-1:0] tap_max_ms;
        logic [CFG_BITS-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 touching;
        logic                 take_tap;
        logic                 take_hold;
    } item_t;

    typedef struct packed {
        logic tap_pending;
        logic hold_pending;
        logic contact_latched;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/thg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thg_regs
// APB configuration registers: latch gap, tap window and hold time.
// ----------------------------------------------------------------------------
module thg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [thg_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output thg_pkg::cfg_t                      cfg
);
    import thg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_LATCH_GAP: cfg_next.latch_gap_ms = pwdata[CFG_BITS-1:0];
                REG_TAP_MIN:   cfg_next.tap_min_ms   = pwdata[CFG_BITS-1:0];
                REG_TAP_MAX:   cfg_next.tap_max_ms   = pwdata[CFG_BITS-1:0];
                REG_HOLD:      cfg_next.hold_ms      = pwdata[CFG_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LATCH_GAP: prdata = {16'd0, cfg_reg.latch_gap_ms};
            REG_TAP_MIN:   prdata = {16'd0, cfg_reg.tap_min_ms};
            REG_TAP_MAX:   prdata = {16'd0, cfg_reg.tap_max_ms};
            REG_HOLD:      prdata = {16'd0, cfg_reg.hold_ms};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.latch_gap_ms <= LATCH_GAP_RST;
            cfg_reg.tap_min_ms   <= TAP_MIN_RST;
            cfg_reg.tap_max_ms   <= TAP_MAX_RST;
            cfg_reg.hold_ms      <= HOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/thg_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thg_core
// Contact latch, tap and hold state, updated once per request.
// ----------------------------------------------------------------------------
module thg_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire thg_pkg::item_t  item,
    input  wire thg_pkg::cfg_t   cfg,
    output thg_pkg::result_t     result
);
    import thg_pkg::*;

    logic                 latched_reg,   latched_next;
    logic                 hold_done_reg, hold_done_next;
    logic                 tap_flag_reg,  tap_flag_next;
    logic                 hold_flag_reg, hold_flag_next;
    logic [TIME_BITS-1:0] last_reg,      last_next;
    logic [TIME_BITS-1:0] start_reg,     start_next;

    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] age;
    logic                 release_hit;
    logic                 tap_hit;
    logic                 hold_hit;
    logic                 tap_set;
    logic                 hold_set;

    always_comb begin
        latched_next   = latched_reg;
        hold_done_next = hold_done_reg;
        last_next      = last_reg;
        start_next     = start_reg;

        if (item.touching) begin
            if (!latched_reg) begin
                start_next     = item.now_ms;
                hold_done_next = 1'b0;
            end
            latched_next = 1'b1;
            last_next    = item.now_ms;
        end

        // differences wrap modulo the time width
        gap = item.now_ms - last_next;
        dur = last_next - start_next;
        release_hit = latched_next && !item.touching
                      && (gap > TIME_BITS'(cfg.latch_gap_ms));
        tap_hit = !hold_done_next && (dur >= TIME_BITS'(cfg.tap_min_ms))
                  && (dur <= TIME_BITS'(cfg.tap_max_ms));
        tap_set = release_hit && tap_hit;
        if (release_hit) begin
            latched_next = 1'b0;
        end

        age      = item.now_ms - start_next;
        hold_hit = latched_next && !hold_done_next
                   && (age > TIME_BITS'(cfg.hold_ms));
        hold_set = hold_hit;
        if (hold_hit) begin
            hold_done_next = 1'b1;
        end

        result.tap_pending     = tap_flag_reg || tap_set;
        result.hold_pending    = hold_flag_reg || hold_set;
        result.contact_latched = latched_next;

        // read-and-clear after reporting
        tap_flag_next  = result.tap_pending && !item.take_tap;
        hold_flag_next = result.hold_pending && !item.take_hold;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg   <= 1'b0;
            hold_done_reg <= 1'b0;
            tap_flag_reg  <= 1'b0;
            hold_flag_reg <= 1'b0;
            last_reg      <= '0;
            start_reg     <= '0;
        end else if (step) begin
            latched_reg   <= latched_next;
            hold_done_reg <= hold_done_next;
            tap_flag_reg  <= tap_flag_next;
            hold_flag_reg <= hold_flag_next;
            last_reg      <= last_next;
            start_reg     <= start_next;
        end
    end

    // a new tap only comes from a release of a contact without hold
    a_tap_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.tap_pending && !tap_flag_reg
        |-> !item.touching && latched_reg && !hold_done_reg)
        else $error("tap raised outside a release");

    // a new hold marks the contact as done
    a_hold_done: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.hold_pending && !hold_flag_reg |=> hold_done_reg)
        else $error("hold raised without hold_done");

    // a touch sample latches and stamps the last touch time
    a_touch_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.touching |=> latched_reg && (last_reg == $past(item.now_ms)))
        else $error("touch did not latch contact");

    // state moves only on a request
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(latched_reg) && $stable(tap_flag_reg) && $stable(hold_flag_reg))
        else $error("state changed without a request");

endmodule
`default_nettype wire

// ===== sv/tap_hold_gesture_detector.sv =====
`default_nettype none
// a request is registered in the input register, then its result in the output register
// throughput: one request per cycle unless stalled, bounded by the single state-update pass
// a stalled result side holds both registers and drops s_ready once the input register is full
// reset: synchronous active-low aresetn clears the latch, times and events,
// and loads the configuration defaults (gap 300, tap 30..1000, hold 1000)
// ----------------------------------------------------------------------------
// tap_hold_gesture_detector
// Touch tap and long-press detector with an APB configuration port.
// ----------------------------------------------------------------------------
module tap_hold_gesture_detector (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [thg_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [thg_pkg::TIME_BITS-1:0] s_now_ms,
    input  wire logic                          s_touching,
    input  wire logic                          s_take_tap,
    input  wire logic                          s_take_hold,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_tap_pending,
    output logic                               m_hold_pending,
    output logic                               m_contact_latched
);
    import thg_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    result_t result;
    logic    out_valid_reg;
    logic    step;

    thg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // the input stage moves on when the result register is free or drains
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.now_ms    <= s_now_ms;
            in_reg.touching  <= s_touching;
            in_reg.take_tap  <= s_take_tap;
            in_reg.take_hold <= s_take_hold;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_tap_pending     = out_reg.tap_pending;
    assign m_hold_pending    = out_reg.hold_pending;
    assign m_contact_latched = out_reg.contact_latched;

endmodule
`default_nettype wire
